// ===== src/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg: system info decoder package
// field widths, frequency constants, duplex spacing table and result type
// ----------------------------------------------------------------------------
`default_nettype none

package sip_pkg;

  localparam int unsigned HEAD_W = 64;
  localparam int unsigned TAIL_W = 14;

  localparam int unsigned BAND_STEP_HZ    = 100_000_000;
  localparam int unsigned CARRIER_STEP_HZ = 25_000;
  localparam int unsigned KHZ_HZ          = 1_000;

  localparam logic signed [14:0] OFFSET_HZ [4] = '{
    15'sd0, 15'sd6250, -15'sd6250, 15'sd12500
  };

  // bit b set when duplex entry [code][b] is reserved
  localparam logic [15:0] RSV_MASK [8] = '{
    16'hFF81, 16'hFCE5, 16'h0000, 16'hFCE7, 16'hFD27, 16'hFFEF, 16'hFFFF, 16'hFFFF
  };

  typedef struct packed {
    logic signed [31:0] downlink_hz;
    logic signed [31:0] uplink_hz;
    logic               uplink_reserved;
    logic [1:0]         secondary_channels;
    logic [2:0]         max_tx_power_code;
    logic [3:0]         min_access_level_code;
    logic [3:0]         access_param_code;
    logic [3:0]         downlink_timeout_code;
    logic               cipher_key_flag;
    logic [15:0]        hyperframe_or_key;
    logic [1:0]         optional_kind;
    logic [19:0]        optional_payload;
  } result_t;

  // duplex spacing in kHz by duplex code and band
  function automatic logic [15:0] spacing_khz(input logic [2:0] code, input logic [3:0] band);
    logic [15:0] sp;
    sp = '0;
    case ({code, band})
      {3'd0, 4'd1}: sp = 16'd1600;
      {3'd0, 4'd2}: sp = 16'd10000;
      {3'd0, 4'd3}: sp = 16'd10000;
      {3'd0, 4'd4}: sp = 16'd10000;
      {3'd0, 4'd5}: sp = 16'd10000;
      {3'd0, 4'd6}: sp = 16'd10000;
      {3'd1, 4'd1}: sp = 16'd4500;
      {3'd1, 4'd3}: sp = 16'd36000;
      {3'd1, 4'd4}: sp = 16'd7000;
      {3'd1, 4'd8}: sp = 16'd45000;
      {3'd1, 4'd9}: sp = 16'd45000;
      {3'd3, 4'd3}: sp = 16'd8000;
      {3'd3, 4'd4}: sp = 16'd8000;
      {3'd3, 4'd8}: sp = 16'd18000;
      {3'd3, 4'd9}: sp = 16'd18000;
      {3'd4, 4'd3}: sp = 16'd18000;
      {3'd4, 4'd4}: sp = 16'd5000;
      {3'd4, 4'd6}: sp = 16'd30000;
      {3'd4, 4'd7}: sp = 16'd30000;
      {3'd4, 4'd9}: sp = 16'd39000;
      {3'd5, 4'd4}: sp = 16'd9500;
      default:      sp = '0;
    endcase
    return sp;
  endfunction

endpackage

`default_nettype wire

// ===== src/sip_if.sv =====
// ----------------------------------------------------------------------------
// sip_if: system info decoder channels
// body request channel and decoded result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface sip_body_if;
  logic                        valid;
  logic                        ready;
  logic [sip_pkg::HEAD_W-1:0]  body_head;
  logic [sip_pkg::TAIL_W-1:0]  body_tail;

  modport source (output valid, body_head, body_tail, input ready);
  modport sink   (input valid, body_head, body_tail, output ready);
endinterface

interface sip_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] downlink_hz;
  logic signed [31:0] uplink_hz;
  logic               uplink_reserved;
  logic [1:0]         secondary_channels;
  logic [2:0]         max_tx_power_code;
  logic [3:0]         min_access_level_code;
  logic [3:0]         access_param_code;
  logic [3:0]         downlink_timeout_code;
  logic               cipher_key_flag;
  logic [15:0]        hyperframe_or_key;
  logic [1:0]         optional_kind;
  logic [19:0]        optional_payload;

  modport source (
    output valid, downlink_hz, uplink_hz, uplink_reserved, secondary_channels,
           max_tx_power_code, min_access_level_code, access_param_code,
           downlink_timeout_code, cipher_key_flag, hyperframe_or_key,
           optional_kind, optional_payload,
    input  ready
  );
  modport sink (
    input  valid, downlink_hz, uplink_hz, uplink_reserved, secondary_channels,
           max_tx_power_code, min_access_level_code, access_param_code,
           downlink_timeout_code, cipher_key_flag, hyperframe_or_key,
           optional_kind, optional_payload,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/sip_calc.sv =====
// ----------------------------------------------------------------------------
// sip_calc: system info field split and frequency calculation
// splits the body, forms downlink and uplink frequency, flags reserved spacing
// ----------------------------------------------------------------------------
`default_nettype none

module sip_calc (
  input  wire logic [sip_pkg::HEAD_W-1:0] head_i,
  input  wire logic [sip_pkg::TAIL_W-1:0] tail_i,
  output sip_pkg::result_t                res_o
);
  import sip_pkg::*;

  logic [11:0]        carrier;
  logic [3:0]         band;
  logic [1:0]         offs;
  logic [2:0]         dcode;
  logic               reverse;
  logic [30:0]        band_hz;
  logic [26:0]        carrier_hz;
  logic [30:0]        base_hz;
  logic signed [14:0] off_hz;
  logic [15:0]        sp_khz;
  logic [25:0]        sp_hz;
  logic signed [27:0] ul_adj;
  logic               rsv;

  assign carrier = head_i[63:52];
  assign band    = head_i[51:48];
  assign offs    = head_i[47:46];
  assign dcode   = head_i[45:43];
  assign reverse = head_i[42];

  assign band_hz    = 31'(band) * 31'(BAND_STEP_HZ);
  assign carrier_hz = 27'(carrier) * 27'(CARRIER_STEP_HZ);
  assign base_hz    = band_hz + 31'(carrier_hz);
  assign off_hz     = OFFSET_HZ[offs];

  assign sp_khz = spacing_khz(dcode, band);
  assign sp_hz  = 26'(sp_khz) * 26'(KHZ_HZ);
  assign rsv    = RSV_MASK[dcode][band];

  // offset and duplex spacing fold together beside the base sum
  assign ul_adj = reverse ? 28'(off_hz) + $signed({2'b00, sp_hz})
                          : 28'(off_hz) - $signed({2'b00, sp_hz});

  always_comb begin
    res_o.downlink_hz           = $signed({1'b0, base_hz}) + 32'(off_hz);
    res_o.uplink_hz             = rsv ? '0 : $signed({1'b0, base_hz}) + 32'(ul_adj);
    res_o.uplink_reserved       = rsv;
    res_o.secondary_channels    = head_i[41:40];
    res_o.max_tx_power_code     = head_i[39:37];
    res_o.min_access_level_code = head_i[36:33];
    res_o.access_param_code     = head_i[32:29];
    res_o.downlink_timeout_code = head_i[28:25];
    res_o.cipher_key_flag       = head_i[24];
    res_o.hyperframe_or_key     = head_i[23:8];
    res_o.optional_kind         = head_i[7:6];
    res_o.optional_payload      = {head_i[5:0], tail_i};
  end

endmodule

`default_nettype wire

// ===== src/sysinfo_pdu_decoder.sv =====
// ----------------------------------------------------------------------------
// sysinfo_pdu_decoder: system info broadcast body decoder
// input register, field split and frequency logic, result register
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  body_i    in         valid/ready        body_head, body_tail
//  result_o  out        valid/ready        frequencies, flags, raw fields
//
//  one request accepted per cycle while result_o is not stalled
//  a result passes through the input register, then the result register
//  result stall: input register still takes one more request
//  reset clears both valid flags only
// ----------------------------------------------------------------------------
`default_nettype none

module sysinfo_pdu_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  sip_body_if.sink        body_i,
  sip_result_if.source    result_o
);
  import sip_pkg::*;

  logic                v1_q;
  logic [HEAD_W-1:0]   head_q;
  logic [TAIL_W-1:0]   tail_q;
  logic                v2_q;
  result_t             res_q;
  result_t             res_d;
  logic                s1_ready;
  logic                s2_ready;

  assign s2_ready     = !v2_q || result_o.ready;
  assign s1_ready     = !v1_q || s2_ready;
  assign body_i.ready = s1_ready;

  sip_calc u_calc (
    .head_i (head_q),
    .tail_i (tail_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1_q <= body_i.valid;
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (body_i.valid && s1_ready) begin
      head_q <= body_i.body_head;
      tail_q <= body_i.body_tail;
    end
    if (v1_q && s2_ready) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid                 = v2_q;
  assign result_o.downlink_hz           = res_q.downlink_hz;
  assign result_o.uplink_hz             = res_q.uplink_hz;
  assign result_o.uplink_reserved       = res_q.uplink_reserved;
  assign result_o.secondary_channels    = res_q.secondary_channels;
  assign result_o.max_tx_power_code     = res_q.max_tx_power_code;
  assign result_o.min_access_level_code = res_q.min_access_level_code;
  assign result_o.access_param_code     = res_q.access_param_code;
  assign result_o.downlink_timeout_code = res_q.downlink_timeout_code;
  assign result_o.cipher_key_flag       = res_q.cipher_key_flag;
  assign result_o.hyperframe_or_key     = res_q.hyperframe_or_key;
  assign result_o.optional_kind         = res_q.optional_kind;
  assign result_o.optional_payload      = res_q.optional_payload;

`ifndef NO_ASSERTIONS
  a_reserved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.uplink_reserved |-> result_o.uplink_hz == 32'sd0)
    else $error("reserved spacing with nonzero uplink");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    body_i.valid && body_i.ready |=> v1_q)
    else $error("accepted request lost in input register");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !s2_ready |=> v1_q && $stable(head_q) && $stable(tail_q))
    else $error("input register changed while blocked");
`endif

endmodule

`default_nettype wire
